>>> rtl/amgt_pkg.sv
package amgt_pkg;

    // Default vertex capacity of the matrix.
    localparam int MAX_VERTICES_DEF = 16;

    // Fixed widths of the item and result fields.
    localparam int FIELD_W    = 4;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_ADDR_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIRECTED     = 1'b1;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_EDGE  = 2'd1,
        KIND_DFS   = 2'd2,
        KIND_BFS   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE_RD,
        ST_EDGE_WR,
        ST_POP,
        ST_ROW,
        ST_PUSH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        kind_t              kind;
        logic [FIELD_W-1:0] start_vertex;
        logic [FIELD_W-1:0] edge_to;
        logic [FIELD_W-1:0] edge_from;
    } item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] vertex;
        logic               last;
    } result_t;

endpackage

>>> rtl/amgt_pick.sv
// Lowest-set-bit finder shared by every neighbor push of a traversal.
module amgt_pick
    import amgt_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    localparam int VW = $clog2(MAX_VERTICES)
)
(
    input  logic [MAX_VERTICES-1:0] mask,
    output logic                    found,
    output logic [VW-1:0]           index
);

    always_comb
    begin
        found = |mask;
        index = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                index = VW'(i);
            end
        end
    end

endmodule

>>> rtl/amgt_seq.sv
// Sequencer: adjacency memory, pending store, visited marks and the
// pop / scan / push / emit loop of both walks.
module amgt_seq
    import amgt_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    localparam int VW = $clog2(MAX_VERTICES),
    localparam int PW = $clog2(MAX_VERTICES + 1),
    localparam int NW = $clog2(MAX_VERTICES + 1),
    localparam int CW = (NW > CFG_DATA_W) ? NW : CFG_DATA_W
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  item_t         item,
    output logic          item_ready,
    input  logic [CW-1:0] count_in_use,
    input  logic          directed,
    input  logic          res_ready,
    output logic          res_valid,
    output result_t       res
);

    localparam int IW = (VW > FIELD_W) ? VW : FIELD_W;

    state_t                  state_reg, state_next;
    kind_t                   kind_reg, kind_next;
    logic [VW-1:0]           row_reg, row_next;
    logic [VW-1:0]           col_reg, col_next;
    logic                    second_reg, second_next;
    logic [VW-1:0]           u_reg, u_next;
    logic [PW-1:0]           head_reg, head_next;
    logic [PW-1:0]           tail_reg, tail_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] row_valid_reg, row_valid_next;

    logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] adj_q_reg;
    logic                    adj_qv_reg;
    logic                    adj_rd_en;
    logic [VW-1:0]           adj_rd_addr;
    logic                    adj_wr_en;
    logic [MAX_VERTICES-1:0] adj_wr_data;

    logic [VW-1:0]           pend_mem [MAX_VERTICES];
    logic [VW-1:0]           pend_q_reg;
    logic                    pend_rd_en;
    logic [VW-1:0]           pend_rd_addr;
    logic                    pend_wr_en;
    logic [VW-1:0]           pend_wr_addr;
    logic [VW-1:0]           pend_wr_data;

    logic [MAX_VERTICES-1:0] range_mask;
    logic [MAX_VERTICES-1:0] adj_row;
    logic [MAX_VERTICES-1:0] cand;
    logic                    pick_found;
    logic [VW-1:0]           pick_idx;
    logic                    empty;
    logic [PW-1:0]           tail_dec;
    logic [PW-1:0]           pop_ptr;
    logic [IW-1:0]           u_wide;
    logic                    edge_ok;
    logic                    start_ok;

    function automatic logic [VW-1:0] to_idx(input logic [FIELD_W-1:0] x);
        logic [IW-1:0] w;
        w = IW'(x);
        return w[VW-1:0];
    endfunction

    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            range_mask[i] = (CW'(i) < count_in_use);
        end
    end

    assign adj_row  = adj_qv_reg ? adj_q_reg : '0;
    assign cand     = adj_row & range_mask & ~visited_reg;
    assign empty    = (kind_reg == KIND_DFS) ? (tail_reg == '0) : (head_reg == tail_reg);
    assign tail_dec = tail_reg - PW'(1);
    assign pop_ptr  = (kind_reg == KIND_DFS) ? tail_dec : head_reg;
    assign u_wide   = IW'(u_reg);
    assign edge_ok  = (CW'(item.edge_from) < count_in_use)
                   && (CW'(item.edge_to) < count_in_use);
    assign start_ok = (CW'(item.start_vertex) < count_in_use);

    amgt_pick #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_pick (
        .mask  (cand),
        .found (pick_found),
        .index (pick_idx)
    );

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        second_next    = second_reg;
        u_next         = u_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        visited_next   = visited_reg;
        row_valid_next = row_valid_reg;
        item_ready     = 1'b0;
        res_valid      = 1'b0;
        res.vertex     = u_wide[FIELD_W-1:0];
        res.last       = empty;
        adj_rd_en      = 1'b0;
        adj_rd_addr    = row_reg;
        adj_wr_en      = 1'b0;
        adj_wr_data    = adj_row | (MAX_VERTICES'(1) << col_reg);
        pend_rd_en     = 1'b0;
        pend_rd_addr   = pop_ptr[VW-1:0];
        pend_wr_en     = 1'b0;
        pend_wr_addr   = tail_reg[VW-1:0];
        pend_wr_data   = pick_idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    kind_next = item.kind;
                    unique case (item.kind) inside
                        KIND_CLEAR:
                        begin
                            row_valid_next = '0;
                        end
                        KIND_EDGE:
                        begin
                            if (edge_ok)
                            begin
                                row_next    = to_idx(item.edge_from);
                                col_next    = to_idx(item.edge_to);
                                second_next = 1'b0;
                                state_next  = ST_EDGE_RD;
                            end
                        end
                        KIND_DFS, KIND_BFS:
                        begin
                            if (start_ok)
                            begin
                                pend_wr_en   = 1'b1;
                                pend_wr_addr = '0;
                                pend_wr_data = to_idx(item.start_vertex);
                                visited_next = MAX_VERTICES'(1) << to_idx(item.start_vertex);
                                head_next    = '0;
                                tail_next    = PW'(1);
                                state_next   = ST_POP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EDGE_RD:
            begin
                adj_rd_en   = 1'b1;
                adj_rd_addr = row_reg;
                state_next  = ST_EDGE_WR;
            end
            ST_EDGE_WR:
            begin
                adj_wr_en               = 1'b1;
                row_valid_next[row_reg] = 1'b1;
                if (!directed && !second_reg)
                begin
                    // Mirror the edge with the row and column swapped.
                    second_next = 1'b1;
                    row_next    = col_reg;
                    col_next    = row_reg;
                    state_next  = ST_EDGE_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP:
            begin
                pend_rd_en = 1'b1;
                if (kind_reg == KIND_DFS)
                begin
                    tail_next = tail_dec;
                end
                else
                begin
                    head_next = head_reg + PW'(1);
                end
                state_next = ST_ROW;
            end
            ST_ROW:
            begin
                u_next      = pend_q_reg;
                adj_rd_en   = 1'b1;
                adj_rd_addr = pend_q_reg;
                state_next  = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (pick_found)
                begin
                    pend_wr_en             = 1'b1;
                    tail_next              = tail_reg + PW'(1);
                    visited_next[pick_idx] = 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (res_ready)
                begin
                    res_valid = 1'b1;
                    if (empty)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // Pop the next vertex in the same cycle as the beat.
                        pend_rd_en = 1'b1;
                        if (kind_reg == KIND_DFS)
                        begin
                            tail_next = tail_dec;
                        end
                        else
                        begin
                            head_next = head_reg + PW'(1);
                        end
                        state_next = ST_ROW;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_CLEAR;
            second_reg    <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            visited_reg   <= '0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            second_reg    <= second_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            visited_reg   <= visited_next;
            row_valid_reg <= row_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        col_reg <= col_next;
        u_reg   <= u_next;
    end

    // Adjacency rows; a row whose valid bit is clear reads as all zero.
    always_ff @(posedge clk)
    begin
        if (adj_wr_en)
        begin
            adj_mem[row_reg] <= adj_wr_data;
        end
        if (adj_rd_en)
        begin
            adj_q_reg  <= adj_mem[adj_rd_addr];
            adj_qv_reg <= row_valid_reg[adj_rd_addr];
        end
    end

    // Stack or queue of vertices still to visit.
    always_ff @(posedge clk)
    begin
        if (pend_wr_en)
        begin
            pend_mem[pend_wr_addr] <= pend_wr_data;
        end
        if (pend_rd_en)
        begin
            pend_q_reg <= pend_mem[pend_rd_addr];
        end
    end

endmodule

>>> rtl/adjacency_matrix_graph_traversal.sv
// Channel   | Signals                                  | Contents (lowest bit first)
// ----------+------------------------------------------+---------------------------------------
// s_axis    | tvalid, tready, tdata[15:0], tuser[1:0]  | tdata: edge_from, edge_to,
//           |                                          |   start_vertex; tuser: kind
// m_axis    | tvalid, tready, tdata[7:0], tlast        | tdata: vertex; tlast: last
// cfg       | cfg_wr_en, cfg_addr, cfg_wdata[4:0]      | 0 vertex_count, 1 directed
//
// A clear beat is taken in the idle step. An edge beat updates the matrix row by a read
// and a write, and when directed is clear it then updates the mirrored row the same way.
// A walk pops each vertex from the pending store, reads its adjacency row, pushes
// its unvisited neighbors one at a time through the shared lowest-bit finder, and
// then emits the vertex as an output beat.
// The input is not ready while an item is in progress; a stalled output holds the
// sequencer in its emit step. Reset clears the matrix row-valid bits at once, so
// no clearing pass is needed.
module adjacency_matrix_graph_traversal
    import amgt_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // edge_from, edge_to, start_vertex, zeros
    input  logic [1:0]            s_axis_tuser,   // kind

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // vertex, zeros
    output logic                  m_axis_tlast,

    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int CW = (NW > CFG_DATA_W) ? NW : CFG_DATA_W;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] vertex_count_reg, vertex_count_next;
    logic                  directed_reg, directed_next;

    // Output register between the sequencer and the master side.
    logic                  out_valid_reg, out_valid_next;
    result_t               out_res_reg, out_res_next;

    logic [CW-1:0]         count_in_use;
    item_t                 item;
    logic                  res_valid;
    result_t               res;
    logic                  res_ready;

    always_comb
    begin
        vertex_count_next = vertex_count_reg;
        directed_next     = directed_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_VERTEX_COUNT: vertex_count_next = cfg_wdata;
                CFG_DIRECTED:     directed_next     = cfg_wdata[0];
                default:          vertex_count_next = vertex_count_reg;
            endcase
        end
    end

    // The count in use saturates at the matrix capacity.
    assign count_in_use = (CW'(vertex_count_reg) > CW'(MAX_VERTICES))
                        ? CW'(MAX_VERTICES) : CW'(vertex_count_reg);

    assign item.kind         = kind_t'(s_axis_tuser);
    assign item.edge_from    = s_axis_tdata[3:0];
    assign item.edge_to      = s_axis_tdata[7:4];
    assign item.start_vertex = s_axis_tdata[11:8];

    // A new result may load when the register is empty or is being drained.
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= CFG_DATA_W'(MAX_VERTICES_DEF);
            directed_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            vertex_count_reg <= vertex_count_next;
            directed_reg     <= directed_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    amgt_seq #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (s_axis_tvalid),
        .item         (item),
        .item_ready   (s_axis_tready),
        .count_in_use (count_in_use),
        .directed     (directed_reg),
        .res_ready    (res_ready),
        .res_valid    (res_valid),
        .res          (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_res_reg.vertex};
    assign m_axis_tlast  = out_res_reg.last;

endmodule

>>> rtl/amgt_check.sv
module amgt_check
    import amgt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [1:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // A stalled output beat keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

    // A clear leaves the input ready again in the next cycle.
    a_clear_fast: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_CLEAR)
        |=> s_axis_tready)
        else $error("input not ready after a clear");

    // While a walk is still producing beats, no new item is taken.
    a_busy_walk: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready in the middle of a walk");

endmodule

bind adjacency_matrix_graph_traversal amgt_check u_amgt_check (.*);
